@@ rtl/hpcd_pkg.sv @@
// hpcd_pkg: shared types and constants of the heatmap peak centroid detector
// no dependencies; imported by every module of the block except hpcd_ram

package hpcd_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_LEVEL_BIAS = 2'd0;
  localparam logic [1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_PEAK_ONLY  = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // result queue between scanner and output stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PW    = 2;

  // output stream data width (41 used bits padded to bytes)
  localparam int unsigned OUT_DATA_W = 48;

  // scan settings, snapshot at frame end
  typedef struct packed {
    logic [7:0]        level_bias;
    logic signed [8:0] threshold;
    logic              peak_only;
  } cfg_t;

  // one queued result, sized for the largest grid
  typedef struct packed {
    logic       is_det;
    logic [5:0] row;
    logic [5:0] col;
    logic [3:0] cls;
    logic [7:0] level;
    logic [5:0] count;
  } rec_t;

endpackage

@@ rtl/hpcd_ram.sv @@
// hpcd_ram: generic simple dual port ram, one write and one registered read
// no dependencies

module hpcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1280
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hpcd_scan.sv @@
// hpcd_scan: raster scan of the stored grid, per-cell argmax, threshold and peak test
// depends on hpcd_pkg; reads the score ram, pushes results into the queue

module hpcd_scan import hpcd_pkg::*; #(
  parameter int unsigned GridRows   = 16,
  parameter int unsigned GridCols   = 16,
  parameter int unsigned ClassCount = 5,
  parameter int unsigned MaxDets    = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  cfg_t                                          cfg_i,
  output logic                                          busy_o,
  output logic                                          rd_en_o,
  output logic [$clog2(GridRows*GridCols*ClassCount)-1:0] rd_addr_o,
  input  logic [7:0]                                    rd_data_i,
  output logic                                          push_o,
  output rec_t                                          rec_o,
  input  logic                                          full_i
);

  localparam int unsigned Depth = GridRows * GridCols * ClassCount;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned RowW  = (GridRows > 1) ? $clog2(GridRows) : 1;
  localparam int unsigned ColW  = (GridCols > 1) ? $clog2(GridCols) : 1;
  localparam int unsigned KW    = $clog2(ClassCount);
  localparam int unsigned RowSz = GridCols * ClassCount;

  localparam logic [AW-1:0]   RowStep  = AW'(RowSz);
  localparam logic [AW-1:0]   CellStep = AW'(ClassCount);
  localparam logic [RowW-1:0] LastRow  = RowW'(GridRows - 1);
  localparam logic [ColW-1:0] LastCol  = ColW'(GridCols - 1);
  localparam logic [KW-1:0]   LastCls  = KW'(ClassCount - 1);
  localparam logic [5:0]      DetLimit = 6'(MaxDets);

  // scan states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLS  = 4'd1;
  localparam logic [3:0] ST_CLW  = 4'd2;
  localparam logic [3:0] ST_EVAL = 4'd3;
  localparam logic [3:0] ST_NBR  = 4'd4;
  localparam logic [3:0] ST_NBW  = 4'd5;
  localparam logic [3:0] ST_NDEC = 4'd6;
  localparam logic [3:0] ST_PUSH = 4'd7;
  localparam logic [3:0] ST_NEXT = 4'd8;
  localparam logic [3:0] ST_SUM  = 4'd9;

  // neighbor directions
  localparam logic [1:0] DIR_UP = 2'd0;
  localparam logic [1:0] DIR_DN = 2'd1;
  localparam logic [1:0] DIR_LT = 2'd2;
  localparam logic [1:0] DIR_RT = 2'd3;

  logic [3:0]        state_q, state_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [AW-1:0]     base_q, base_d;
  logic [KW-1:0]     cls_q, cls_d;
  logic [KW-1:0]     rcls_q, rcls_d;
  logic [KW-1:0]     bcls_q, bcls_d;
  logic signed [8:0] best_q, best_d;
  logic [1:0]        dir_q, dir_d;
  logic              fail_q, fail_d;
  logic              rv_q, rv_d;
  logic              nv_q, nv_d;
  logic [5:0]        found_q, found_d;
  cfg_t              cfg_q, cfg_d;

  logic signed [8:0] lvl;
  logic              nb_exists;
  logic [AW-1:0]     nb_off;

  // level of the word read last cycle
  assign lvl = $signed({rd_data_i[7], rd_data_i}) -
               $signed({cfg_q.level_bias[7], cfg_q.level_bias});

  // neighbor address and edge check
  always_comb begin
    nb_exists = 1'b0;
    nb_off    = base_q;
    case (dir_q)
      DIR_UP: begin
        nb_exists = (row_q != '0);
        nb_off    = base_q - RowStep;
      end
      DIR_DN: begin
        nb_exists = (row_q != LastRow);
        nb_off    = base_q + RowStep;
      end
      DIR_LT: begin
        nb_exists = (col_q != '0);
        nb_off    = base_q - CellStep;
      end
      DIR_RT: begin
        nb_exists = (col_q != LastCol);
        nb_off    = base_q + CellStep;
      end
      default: begin
        nb_exists = 1'b0;
        nb_off    = base_q;
      end
    endcase
  end

  // scan sequencer
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    base_d    = base_q;
    cls_d     = cls_q;
    rcls_d    = rcls_q;
    bcls_d    = bcls_q;
    best_d    = best_q;
    dir_d     = dir_q;
    fail_d    = fail_q;
    rv_d      = 1'b0;
    nv_d      = 1'b0;
    found_d   = found_q;
    cfg_d     = cfg_q;
    rd_en_o   = 1'b0;
    rd_addr_o = base_q;
    push_o    = 1'b0;
    rec_o     = '0;

    // compare returning words against the running best
    if (rv_q && (lvl > best_q)) begin
      best_d = lvl;
      bcls_d = rcls_q;
    end
    if (nv_q && (lvl > best_q)) begin
      fail_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cfg_d   = cfg_i;
          row_d   = '0;
          col_d   = '0;
          base_d  = '0;
          cls_d   = KW'(1);
          best_d  = '0;
          bcls_d  = '0;
          found_d = '0;
          state_d = ST_CLS;
        end
      end
      ST_CLS: begin
        rd_en_o   = 1'b1;
        rd_addr_o = base_q + AW'(cls_q);
        rv_d      = 1'b1;
        rcls_d    = cls_q;
        if (cls_q == LastCls) begin
          state_d = ST_CLW;
        end else begin
          cls_d = cls_q + KW'(1);
        end
      end
      ST_CLW: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (best_q < $signed(cfg_q.threshold)) begin
          state_d = ST_NEXT;
        end else if (cfg_q.peak_only) begin
          dir_d   = DIR_UP;
          fail_d  = 1'b0;
          state_d = ST_NBR;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_NBR: begin
        rd_en_o   = 1'b1;
        rd_addr_o = nb_exists ? (nb_off + AW'(bcls_q)) : base_q;
        nv_d      = nb_exists;
        dir_d     = dir_q + 2'd1;
        if (dir_q == DIR_RT) begin
          state_d = ST_NBW;
        end
      end
      ST_NBW: begin
        state_d = ST_NDEC;
      end
      ST_NDEC: begin
        state_d = fail_q ? ST_NEXT : ST_PUSH;
      end
      ST_PUSH: begin
        if (!full_i) begin
          push_o       = 1'b1;
          rec_o.is_det = 1'b1;
          rec_o.row    = 6'(row_q);
          rec_o.col    = 6'(col_q);
          rec_o.cls    = 4'(bcls_q);
          rec_o.level  = best_q[7:0];
          found_d      = found_q + 6'd1;
          state_d      = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if ((found_q == DetLimit) || ((row_q == LastRow) && (col_q == LastCol))) begin
          state_d = ST_SUM;
        end else begin
          if (col_q == LastCol) begin
            col_d = '0;
            row_d = row_q + RowW'(1);
          end else begin
            col_d = col_q + ColW'(1);
          end
          base_d  = base_q + CellStep;
          cls_d   = KW'(1);
          best_d  = '0;
          bcls_d  = '0;
          state_d = ST_CLS;
        end
      end
      ST_SUM: begin
        if (!full_i) begin
          push_o      = 1'b1;
          rec_o.count = found_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rv_q    <= 1'b0;
      nv_q    <= 1'b0;
      found_q <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      nv_q    <= nv_d;
      found_q <= found_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    base_q <= base_d;
    cls_q  <= cls_d;
    rcls_q <= rcls_d;
    bcls_q <= bcls_d;
    best_q <= best_d;
    dir_q  <= dir_d;
    fail_q <= fail_d;
    cfg_q  <= cfg_d;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ rtl/hpcd_fifo.sv @@
// hpcd_fifo: short result queue between the scanner and the output stage
// depends on hpcd_pkg (rec_t, queue depth)

module hpcd_fifo import hpcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  input  logic pop_i,
  output rec_t rec_o,
  output logic empty_o
);

  rec_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_q, rd_q;
  logic [QUEUE_PW:0]   cnt_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QUEUE_PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QUEUE_PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QUEUE_PW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QUEUE_PW+1)'(1);
      end
    end
  end

  assign full_o  = (cnt_q == (QUEUE_PW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_q];

endmodule

@@ rtl/hpcd_emit.sv @@
// hpcd_emit: output stage, formats queued results and holds the stream register
// depends on hpcd_pkg (rec_t, output width)

module hpcd_emit import hpcd_pkg::*; #(
  parameter int unsigned CellStride = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rec_t                  rec_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  tvalid_o,
  input  logic                  tready_i,
  output logic [OUT_DATA_W-1:0] tdata_o,
  output logic                  tuser_o,
  output logic                  tlast_o
);

  logic                  vld_q;
  logic [OUT_DATA_W-1:0] data_q, data_d;
  logic                  user_q;
  logic                  last_q;
  logic [13:0]           cx_full, cy_full;
  logic [7:0]            cx, cy;

  // centroid in half pixels: (2*index + 1) * stride, wrapped to 8 bits
  assign cx_full = 14'({rec_i.col, 1'b1}) * 14'(CellStride);
  assign cy_full = 14'({rec_i.row, 1'b1}) * 14'(CellStride);
  assign cx      = rec_i.is_det ? cx_full[7:0] : 8'd0;
  assign cy      = rec_i.is_det ? cy_full[7:0] : 8'd0;

  // pack payload, lowest field first
  assign data_d = {7'd0, rec_i.count, cy, cx, rec_i.level, rec_i.cls[2:0],
                   rec_i.col[3:0], rec_i.row[3:0]};

  assign pop_o = !empty_i && (!vld_q || tready_i);

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (tready_i) begin
      vld_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      user_q <= rec_i.is_det;
      last_q <= !rec_i.is_det;
    end
  end

  assign tvalid_o = vld_q;
  assign tdata_o  = data_q;
  assign tuser_o  = user_q;
  assign tlast_o  = last_q;

endmodule

@@ rtl/heatmap_peak_centroid_detector_top.sv @@
// Heatmap peak centroid detector. Scores stream in one per cycle in row, column, class
// order and are written to the score ram; input is taken at one score per cycle while
// loading. The last score of a grid starts the scan, and the input stalls until the scan
// is done (results may still be draining). The scan is set by the single ram read port:
// for each cell the scanner reads classes 1 to ClassCount-1 for the class argmax, waits
// for the last word to return and takes a decision; when peak_only is set and the cell
// passes threshold it then reads the four neighbors in the best class and waits for the
// last one before deciding. A passing cell is queued as a detection, then the scan steps
// on; a dropped cell steps on directly. The summary is queued when the grid scan ends.
// Results go through a four-entry queue and an output register, so a stalled output only
// holds the scan once the queue fills. The store needs no clearing after reset: every
// entry is written before a read.
// Depends on hpcd_pkg, hpcd_ram, hpcd_scan, hpcd_fifo and hpcd_emit.

module heatmap_peak_centroid_detector_top import hpcd_pkg::*; #(
  parameter int unsigned GridRows   = 16,
  parameter int unsigned GridCols   = 16,
  parameter int unsigned ClassCount = 5,
  parameter int unsigned CellStride = 8,
  parameter int unsigned MaxDets    = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // score input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] score_raw
  // result output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [3:0] grid_row, [7:4] grid_col,
                                                // [10:8] class_index, [18:11] score_level,
                                                // [26:19] center_x_half,
                                                // [34:27] center_y_half,
                                                // [40:35] detection_count, rest zero
  output logic                  m_axis_tuser,   // [0] is_detection
  output logic                  m_axis_tlast    // last_result
);

  localparam int unsigned Depth = GridRows * GridCols * ClassCount;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  cfg_t          cfg_q;
  logic [AW-1:0] ld_q;
  logic          in_xfer;
  logic          start;
  logic          scan_busy;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          push;
  rec_t          push_rec;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  rec_t          head_rec;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_bias <= 8'd0;
      cfg_q.threshold  <= 9'sd128;
      cfg_q.peak_only  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEVEL_BIAS: cfg_q.level_bias <= cfg_data_i[7:0];
        REG_THRESHOLD:  cfg_q.threshold  <= $signed(cfg_data_i[8:0]);
        REG_PEAK_ONLY:  cfg_q.peak_only  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // front: score loading, frame end starts the scan
  assign s_axis_tready = !scan_busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign start         = in_xfer && (ld_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_q <= '0;
    end else if (in_xfer) begin
      ld_q <= (ld_q == LastIdx) ? '0 : ld_q + AW'(1);
    end
  end

  hpcd_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (ld_q),
    .wdata_i (s_axis_tdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // cell scanner
  hpcd_scan #(
    .GridRows   (GridRows),
    .GridCols   (GridCols),
    .ClassCount (ClassCount),
    .MaxDets    (MaxDets)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cfg_i     (cfg_q),
    .busy_o    (scan_busy),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .push_o    (push),
    .rec_o     (push_rec),
    .full_i    (q_full)
  );

  // result queue
  hpcd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .rec_o   (head_rec),
    .empty_o (q_empty)
  );

  // back: result formatting and output register
  hpcd_emit #(
    .CellStride (CellStride)
  ) u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rec_i    (head_rec),
    .empty_i  (q_empty),
    .pop_o    (pop),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tuser_o  (m_axis_tuser),
    .tlast_o  (m_axis_tlast)
  );

  // scanner never writes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("result pushed into full queue");

  // summary count stays within the detection limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !push_rec.is_det) |-> (push_rec.count <= 6'(MaxDets)))
    else $error("detection count above limit");

  // a frame end wraps the load index and starts the scan
  a_start_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (scan_busy && (ld_q == '0)))
    else $error("scan start without load index wrap");

endmodule
